// ===== design/double_hash_table_defines.svh =====
// Assertion macros shared by the double hash table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DOUBLE_HASH_TABLE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DHT_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DHT_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dht_pkg.sv =====
// Types, codes and constants for the double hash table.
// No dependencies; imported by every module of the block.
package dht_pkg;

    localparam int KEY_W            = 32;
    localparam int VALUE_W          = 32;
    localparam int HASH_W           = 32;
    localparam int CFG_W            = 11;
    localparam int SLOT_IDX_W       = 10;
    localparam int PROBE_W          = 11;
    localparam int DEFAULT_CAPACITY = 1024;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // remainder unit: bits of the dividend retired per cycle
    localparam int MOD_DIGITS = 4;
    localparam int MOD_CYCLES = HASH_W / MOD_DIGITS;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    typedef enum logic {
        CMD_SEARCH = 1'b0,
        CMD_INSERT = 1'b1
    } command_t;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FAIL = 1'b1
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_BASE,
        ST_MOD_STEP,
        ST_READ,
        ST_CHECK
    } state_t;

    typedef struct packed {
        command_t             command;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
        logic [HASH_W-1:0]    hash_primary;
        logic [HASH_W-1:0]    hash_step;
    } request_t;

    typedef struct packed {
        status_t                status;
        logic [VALUE_W-1:0]     found_value;
        logic [SLOT_IDX_W-1:0]  slot_index;
        logic [PROBE_W-1:0]     probe_count;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

// ===== design/dht_mod_unit.sv =====
// Iterative remainder unit: dividend mod divisor, MOD_DIGITS bits per cycle.
// Depends on dht_pkg.
module dht_mod_unit
    import dht_pkg::*;
#(
    parameter int CNT_W = $clog2(DEFAULT_CAPACITY + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  remainder
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;
    logic [HASH_W-1:0]    dvd_reg;
    logic [HASH_W-1:0]    dvd_next;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic                 last_digit;

    assign last_digit = (cnt_reg == MOD_CNT_W'(MOD_CYCLES - 1));

    always_comb
    begin
        logic [CNT_W:0]    part;
        logic [HASH_W-1:0] bits;
        part      = {1'b0, rem_reg};
        bits      = dvd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        // restoring step per bit; partial remainder stays below divisor
        for (int i = 0; i < MOD_DIGITS; i++)
        begin
            part = {part[CNT_W-1:0], bits[HASH_W-1]};
            bits = {bits[HASH_W-2:0], 1'b0};
            if (part >= {1'b0, divisor})
            begin
                part = part - {1'b0, divisor};
            end
        end
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = bits;
            rem_next = part[CNT_W-1:0];
            cnt_next = cnt_reg + MOD_CNT_W'(1);
            if (last_digit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/dht_store.sv =====
// Slot memory: valid bit, key and value per slot, one write and one read port.
// Depends on dht_pkg.
module dht_store
    import dht_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                        clk,
    input  mem_ctl_t                    mem_ctl,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  entry_t                      wr_data,
    output entry_t                      rd_data
);

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dht_ctrl.sv =====
// Sequencer: clearing pass, two remainder passes, probe loop and result word.
// Depends on dht_pkg and double_hash_table_defines.svh.
`include "double_hash_table_defines.svh"

module dht_ctrl
    import dht_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  request_t                            request,
    input  logic [$clog2(CAPACITY + 1)-1:0]     table_n,
    output logic                                done,
    output result_t                             result,
    output logic                                mod_start,
    output logic [HASH_W-1:0]                   mod_dividend,
    input  logic                                mod_done,
    input  logic [$clog2(CAPACITY + 1)-1:0]     mod_rem,
    output mem_ctl_t                            mem_ctl,
    output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
    output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
    output entry_t                              mem_wr_data,
    input  entry_t                              mem_rd_data
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = SLOT_W + 1;

    state_t            state_reg;
    state_t            state_next;
    request_t          req_reg;
    request_t          req_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] step_reg;
    logic [SLOT_W-1:0] step_next;
    logic [CNT_W-1:0]  probes_reg;
    logic [CNT_W-1:0]  probes_next;
    logic [SLOT_W-1:0] clr_cnt_reg;
    logic [SLOT_W-1:0] clr_cnt_next;
    result_t           result_reg;
    result_t           result_next;
    logic              done_reg;
    logic              done_next;

    logic              occupied;
    logic              match;
    logic              probe_more;
    logic              clr_last;
    logic [SUM_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] slot_wrap;

    assign occupied   = mem_rd_data.valid;
    assign match      = occupied && (mem_rd_data.key == req_reg.key);
    assign probe_more = occupied && !match && (probes_reg < table_n);
    assign clr_last   = (clr_cnt_reg == SLOT_W'(CAPACITY - 1));

    // slot and step are both below n, so one subtract wraps the sum
    assign slot_sum  = {1'b0, slot_reg} + {1'b0, step_reg};
    assign slot_wrap = (slot_sum >= SUM_W'(table_n))
                     ? SLOT_W'(slot_sum - SUM_W'(table_n))
                     : slot_sum[SLOT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MOD_BASE;
                end
            end
            ST_MOD_BASE:
            begin
                if (mod_done)
                begin
                    state_next = ST_MOD_STEP;
                end
            end
            ST_MOD_STEP:
            begin
                if (mod_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = probe_more ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next          = req_reg;
        slot_next         = slot_reg;
        step_next         = step_reg;
        probes_next       = probes_reg;
        clr_cnt_next      = clr_cnt_reg;
        result_next       = result_reg;
        done_next         = 1'b0;
        mod_start         = 1'b0;
        mod_dividend      = request.hash_primary;
        mem_ctl           = '0;
        mem_rd_addr       = slot_reg;
        mem_wr_addr       = slot_reg;
        mem_wr_data.valid = 1'b1;
        mem_wr_data.key   = req_reg.key;
        mem_wr_data.value = req_reg.value;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = clr_cnt_reg;
                mem_wr_data   = '0;
                clr_cnt_next  = clr_cnt_reg + SLOT_W'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next  = request;
                    mod_start = 1'b1;
                end
            end
            ST_MOD_BASE:
            begin
                mod_dividend = req_reg.hash_step;
                if (mod_done)
                begin
                    slot_next = SLOT_W'(mod_rem);
                    mod_start = 1'b1;
                end
            end
            ST_MOD_STEP:
            begin
                mod_dividend = req_reg.hash_step;
                if (mod_done)
                begin
                    step_next   = SLOT_W'(mod_rem);
                    probes_next = CNT_W'(1);
                end
            end
            ST_READ:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            ST_CHECK:
            begin
                if (probe_more)
                begin
                    probes_next = probes_reg + CNT_W'(1);
                    slot_next   = slot_wrap;
                end
                else
                begin
                    done_next               = 1'b1;
                    result_next.slot_index  = SLOT_IDX_W'(slot_reg);
                    result_next.probe_count = PROBE_W'(probes_reg);
                    result_next.found_value = '0;
                    if (req_reg.command == CMD_INSERT)
                    begin
                        // a different key in the last slot means the chain is full
                        if (occupied && !match)
                        begin
                            result_next.status = STATUS_FAIL;
                        end
                        else
                        begin
                            result_next.status = STATUS_OK;
                            mem_ctl.wr_en      = 1'b1;
                        end
                    end
                    else if (match)
                    begin
                        result_next.status      = STATUS_OK;
                        result_next.found_value = mem_rd_data.value;
                    end
                    else
                    begin
                        result_next.status = STATUS_FAIL;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        slot_reg   <= slot_next;
        step_reg   <= step_next;
        probes_reg <= probes_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `DHT_ASSERT_IMP(a_rd_wr_excl, clk, rst_n, mem_ctl.rd_en, !mem_ctl.wr_en, "read and write in one cycle")
    `DHT_ASSERT_NXT(a_accept_starts, clk, rst_n, start && !busy, state_reg == ST_MOD_BASE, "accepted word did not start remainder")
    `DHT_ASSERT_NXT(a_done_single, clk, rst_n, done, !done, "result strobe held two cycles")
    `DHT_ASSERT_IMP(a_probe_nonzero, clk, rst_n, done, result.probe_count != '0, "result with zero probes")

endmodule

// ===== design/double_hash_table.sv =====
// Top level of the double-hashing key/value table: config register and wiring.
// Depends on dht_pkg, dht_mod_unit, dht_store and dht_ctrl.
//
//  Port group              Dir  Handshake               Word
//  request                 in   start && !busy          request_t
//  result                  out  done (one-cycle strobe) result_t
//  cfg_data                in   cfg_write               table_size
//
//  After reset a clearing pass writes every slot, with busy high.
//  A search or insert then runs two remainder passes on the shared 4-bit-per-cycle
//  unit, then one registered slot-memory read and key compare per probe.
//  busy drops in the cycle done is high; the receiver cannot stall the result.
module double_hash_table
    import dht_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  request_t         request,
    output logic             done,
    output result_t          result,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [CFG_W-1:0]  table_size_reg;
    logic [CNT_W-1:0]  table_n;
    logic              mod_start;
    logic [HASH_W-1:0] mod_dividend;
    logic              mod_done;
    logic [CNT_W-1:0]  mod_rem;
    mem_ctl_t          mem_ctl;
    logic [SLOT_W-1:0] mem_rd_addr;
    logic [SLOT_W-1:0] mem_wr_addr;
    entry_t            mem_wr_data;
    entry_t            mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            table_size_reg <= cfg_data;
        end
    end

    // zero or oversize falls back to the full table
    assign table_n = ((table_size_reg == '0) || (32'(table_size_reg) > 32'(CAPACITY)))
                   ? CNT_W'(CAPACITY)
                   : CNT_W'(table_size_reg);

    dht_mod_unit #(
        .CNT_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (table_n),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    dht_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    dht_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .table_n      (table_n),
        .done         (done),
        .result       (result),
        .mod_start    (mod_start),
        .mod_dividend (mod_dividend),
        .mod_done     (mod_done),
        .mod_rem      (mod_rem),
        .mem_ctl      (mem_ctl),
        .mem_rd_addr  (mem_rd_addr),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_data  (mem_rd_data)
    );

endmodule
